// File: sv/aesinv_pkg.sv
// Shared types, op codes and GF(2^8) helpers for the AES inverse round transforms.
// No dependencies; used by every module of aes_inverse_round_ops.
package aesinv_pkg;

    typedef logic [7:0]        byte_t;
    typedef logic [15:0][7:0]  state_t;

    // Transform selector carried on s_op
    typedef enum logic [1:0] {
        OP_INV_SUB   = 2'd0,
        OP_INV_SHIFT = 2'd1,
        OP_INV_MIX   = 2'd2,
        OP_PASS      = 2'd3
    } op_t;

    // Beat held in the input stage
    typedef struct packed {
        op_t    op;
        state_t state;
    } in_beat_t;

    // Beat held after the lookup stage: finished bytes for every op but
    // inverse mix, and the x2/x4/x8 multiples that inverse mix combines
    typedef struct packed {
        logic   is_mix;
        state_t base;
        state_t x2;
        state_t x4;
        state_t x8;
    } mid_beat_t;

    localparam byte_t GF_POLY_LOW = 8'h1b;

    // Standard AES inverse S-box
    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x modulo x^8+x^4+x^3+x+1
    function automatic byte_t xtime(input byte_t v);
        byte_t r;
        r = {v[6:0], 1'b0};
        if (v[7]) begin
            r = r ^ GF_POLY_LOW;
        end
        return r;
    endfunction

endpackage

// File: sv/aes_inverse_round_ops.sv
// Applies InvSubBytes, InvShiftRows or InvMixColumns (or passes through) to
// a 16-byte AES state in a three-stage pipeline: input register, lookup and
// multiples stage, mix and output register. One beat is taken per cycle while
// m_ready stays high, and each result passes through all three registers in turn;
// every stage holds its beat under backpressure and fills bubbles on its own.
// Depends on aesinv_pkg, aesinv_lookup and aesinv_mix.
module aes_inverse_round_ops (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_state_low,
    input  logic [63:0] s_state_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_low,
    output logic [63:0] m_result_high
);
    import aesinv_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_beat_reg, in_beat_next;
    logic      mid_ready;
    logic      mid_valid;
    mid_beat_t mid_beat;
    logic      mix_ready;
    state_t    result;

    // Input stage: take a beat when empty or when it moves on
    assign s_ready = !in_valid_reg || mid_ready;

    always_comb begin
        in_beat_next.op    = op_t'(s_op);
        in_beat_next.state = {s_state_high, s_state_low};
        in_valid_next      = s_ready ? s_valid : in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= in_beat_next;
        end
    end

    aesinv_lookup u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (mid_ready),
        .in_beat   (in_beat_reg),
        .out_valid (mid_valid),
        .out_ready (mix_ready),
        .out_beat  (mid_beat)
    );

    aesinv_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mix_ready),
        .in_beat   (mid_beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_state (result)
    );

    assign m_result_low  = result[7:0];
    assign m_result_high = result[15:8];

endmodule

// File: sv/aesinv_lookup.sv
// Second pipeline stage: inverse S-box lookup, inverse row shift and the
// x2/x4/x8 multiples for inverse mix. Depends on aesinv_pkg.
module aesinv_lookup (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  aesinv_pkg::in_beat_t  in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output aesinv_pkg::mid_beat_t out_beat
);
    import aesinv_pkg::*;

    logic      valid_reg, valid_next;
    mid_beat_t beat_reg, beat_next;
    state_t    sub_bytes;
    state_t    shift_bytes;

    // Take a new beat when empty or when the next stage drains this one
    assign in_ready = !valid_reg || out_ready;

    // Inverse S-box on all sixteen lanes
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sub_bytes[i] = INV_SBOX[in_beat.state[i]];
        end
    end

    // Rotate row r right by r: column c takes from column (c - r) mod 4
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shift_bytes[4*c + r] = in_beat.state[4*((c - r) & 3) + r];
            end
        end
    end

    // Build next beat: finished bytes or the multiples for inverse mix
    always_comb begin
        beat_next.is_mix = (in_beat.op == OP_INV_MIX);
        case (in_beat.op)
            OP_INV_SUB:   beat_next.base = sub_bytes;
            OP_INV_SHIFT: beat_next.base = shift_bytes;
            default:      beat_next.base = in_beat.state;
        endcase
        for (int i = 0; i < 16; i++) begin
            beat_next.x2[i] = xtime(in_beat.state[i]);
            beat_next.x4[i] = xtime(xtime(in_beat.state[i]));
            beat_next.x8[i] = xtime(xtime(xtime(in_beat.state[i])));
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload only on an accepted beat
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: sv/aesinv_mix.sv
// Third pipeline stage and output register: combines the multiples into the
// 14/11/13/9 inverse mix columns product, or passes finished bytes on. Depends on aesinv_pkg.
module aesinv_mix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  aesinv_pkg::mid_beat_t in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output aesinv_pkg::state_t    out_state
);
    import aesinv_pkg::*;

    logic   valid_reg, valid_next;
    state_t state_reg, state_next;
    state_t m9, m11, m13, m14;

    assign in_ready = !valid_reg || out_ready;

    // Per-byte products from the x1/x2/x4/x8 terms
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            m9[i]  = in_beat.x8[i] ^ in_beat.base[i];
            m11[i] = in_beat.x8[i] ^ in_beat.x2[i] ^ in_beat.base[i];
            m13[i] = in_beat.x8[i] ^ in_beat.x4[i] ^ in_beat.base[i];
            m14[i] = in_beat.x8[i] ^ in_beat.x4[i] ^ in_beat.x2[i];
        end
    end

    // Mix each column, or pass finished bytes
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (in_beat.is_mix) begin
                    state_next[4*c + r] = m14[4*c + r]
                                        ^ m11[4*c + ((r + 1) & 3)]
                                        ^ m13[4*c + ((r + 2) & 3)]
                                        ^ m9[4*c + ((r + 3) & 3)];
                end else begin
                    state_next[4*c + r] = in_beat.base[4*c + r];
                end
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// File: sv/aesinv_checker.sv
// Port-level checks for aes_inverse_round_ops, bound to the top level.
// Depends on aesinv_pkg for the op codes.
module aesinv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_op,
    input logic [63:0] s_state_low,
    input logic [63:0] s_state_high,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result_low,
    input logic [63:0] m_result_high
);
    import aesinv_pkg::*;

    // Reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat presented right after reset");

    // A draining output never stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // Stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_low)
                                && $stable(m_result_high))
        else $error("stalled result beat changed");

    // Pass-through beat with a free output arrives at the output intact
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_PASS) ##1 m_ready ##1 m_ready
        |=> m_valid && (m_result_low == $past(s_state_low, 3))
            && (m_result_high == $past(s_state_high, 3)))
        else $error("pass-through beat lost or corrupted");

endmodule

bind aes_inverse_round_ops aesinv_checker u_aesinv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_op          (s_op),
    .s_state_low   (s_state_low),
    .s_state_high  (s_state_high),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_low  (m_result_low),
    .m_result_high (m_result_high)
);

// File: sim/testbench.sv
// Self-checking testbench for aes_inverse_round_ops: directed and random AES inverse
// transforms, checked beat by beat against a predictor built here. Depends on aesinv_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aesinv_pkg::*;

    typedef struct {
        op_t    op;
        state_t st;
    } op_beat_t;

    typedef struct {
        logic [63:0] low;
        logic [63:0] high;
    } result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_PASS;
    logic [63:0] s_state_low = '0;
    logic [63:0] s_state_high = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_low;
    logic [63:0] m_result_high;

    op_beat_t queued_beats[$];
    result_t  transformed_q[$];
    byte_t    inv_sub_tab [256];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       mismatches = 0;
    logic     in_taken = 1'b0;

    aes_inverse_round_ops u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_state_low   (s_state_low),
        .s_state_high  (s_state_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_low  (m_result_low),
        .m_result_high (m_result_high)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // GF(2^8) product modulo x^8+x^4+x^3+x+1, shift and add
    function automatic byte_t gf_times(input byte_t v, input byte_t m);
        byte_t acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (m[k]) begin
                acc = acc ^ v;
            end
            v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Expected output state for one input beat
    function automatic result_t inverse_transform(input op_t op, input state_t s);
        state_t  t;
        result_t res;
        case (op)
            OP_INV_SUB: begin
                for (int i = 0; i < 16; i++) begin
                    t[i] = inv_sub_tab[s[i]];
                end
            end
            OP_INV_SHIFT: begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        t[4*c+r] = s[4*((c + 4 - r) % 4) + r];
                    end
                end
            end
            OP_INV_MIX: begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        t[4*c+r] = gf_times(s[4*c + r], 8'd14)
                                 ^ gf_times(s[4*c + (r + 1) % 4], 8'd11)
                                 ^ gf_times(s[4*c + (r + 2) % 4], 8'd13)
                                 ^ gf_times(s[4*c + (r + 3) % 4], 8'd9);
                    end
                end
            end
            default: begin
                t = s;
            end
        endcase
        res.low  = t[7:0];
        res.high = t[15:8];
        return res;
    endfunction

    // Random state, biased toward the extreme byte values
    function automatic state_t rand_state();
        state_t s;
        for (int i = 0; i < 16; i++) begin
            case ($urandom_range(7))
                0: s[i] = 8'h00;
                1: s[i] = 8'hff;
                2: s[i] = 8'h80;
                default: s[i] = byte_t'($urandom);
            endcase
        end
        return s;
    endfunction

    // Queue n random beats under the given idle mix and wait until the driver has taken them all
    task automatic run_phase(input int send_idle, input int recv_stall, input int n);
        op_beat_t b;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        for (int i = 0; i < n; i++) begin
            b.op = op_t'($urandom_range(3));
            b.st = rand_state();
            queued_beats.push_back(b);
        end
        while (queued_beats.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Input driver: advance to the next queued beat once the current one is taken
    always @(negedge aclk) begin : drive
        op_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (queued_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = queued_beats.pop_front();
                s_op         <= nxt.op;
                s_state_low  <= nxt.st[7:0];
                s_state_high <= nxt.st[15:8];
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side backpressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on every accepted input beat, check every accepted result beat
    always @(posedge aclk) begin : monitor
        result_t exp_res;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            transformed_q.push_back(inverse_transform(op_t'(s_op), {s_state_high, s_state_low}));
        end
        if (aresetn && m_valid && m_ready) begin
            if (transformed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: low %h high %h",
                             m_result_low, m_result_high);
                end
            end else begin
                exp_res = transformed_q.pop_front();
                if (m_result_low !== exp_res.low) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result_low mismatch: expected %h actual %h",
                                 exp_res.low, m_result_low);
                    end
                end
                if (m_result_high !== exp_res.high) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result_high mismatch: expected %h actual %h",
                                 exp_res.high, m_result_high);
                    end
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        byte_t    inv_x;
        byte_t    b;
        op_beat_t d;
        state_t   patterns [5];

        // Build the inverse S-box from the field inverse and the affine map
        for (int x = 0; x < 256; x++) begin
            inv_x = '0;
            for (int y = 1; y < 256 && x != 0; y++) begin
                if (gf_times(byte_t'(x), byte_t'(y)) == 8'h01) begin
                    inv_x = byte_t'(y);
                end
            end
            b = inv_x ^ {inv_x[6:0], inv_x[7]} ^ {inv_x[5:0], inv_x[7:6]}
              ^ {inv_x[4:0], inv_x[7:5]} ^ {inv_x[3:0], inv_x[7:4]} ^ 8'h63;
            inv_sub_tab[b] = byte_t'(x);
        end

        // Hold reset, then release it on a falling clock edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every op over zeros, ones, counting bytes, top bits, alternating
        patterns[0] = '0;
        patterns[1] = '1;
        for (int i = 0; i < 16; i++) begin
            patterns[2][i] = byte_t'(i);
            patterns[3][i] = 8'h80;
            patterns[4][i] = i[0] ? 8'haa : 8'h55;
        end
        for (int p = 0; p < 5; p++) begin
            for (int o = 0; o < 4; o++) begin
                d.op = op_t'(o);
                d.st = patterns[p];
                queued_beats.push_back(d);
            end
        end
        while (queued_beats.size() != 0) begin
            @(posedge aclk);
        end

        // Random phases with different idle mixes
        run_phase(0, 0, 160);
        run_phase(59, 0, 160);
        run_phase(0, 59, 160);
        run_phase(11, 11, 170);

        // Drain outstanding results, then allow for pipeline latency
        while (s_valid || transformed_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && transformed_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
sv/aesinv_pkg.sv
sv/aesinv_lookup.sv
sv/aesinv_mix.sv
sv/aes_inverse_round_ops.sv
sv/aesinv_checker.sv
sim/testbench.sv
